// File: src/lvp_pkg.sv
package lvp_pkg;

   localparam int SYMBOL_W          = 8;
   localparam int LONGEST_W         = 17;
   localparam int DEF_STACK_DEPTH   = 64;
   localparam int DEF_POSITION_BITS = 16;

   localparam logic [SYMBOL_W-1:0] SYM_OPEN  = 8'h28;
   localparam logic [SYMBOL_W-1:0] SYM_CLOSE = 8'h29;

   typedef struct packed {
      logic push;
      logic pop;
      logic load;
   } cell_cmd_type;

endpackage

// File: src/lvp_intf.sv
interface lvp_req_if;
   import lvp_pkg::*;

   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                first;

   modport source (output valid, symbol, first, input ready);
   modport sink   (input valid, symbol, first, output ready);
endinterface

interface lvp_rsp_if;
   import lvp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [LONGEST_W-1:0] longest;
   logic                 overflow;

   modport source (output valid, longest, overflow, input ready);
   modport sink   (input valid, longest, overflow, output ready);
endinterface

// File: src/lvp_cell.sv
module lvp_cell #(
   parameter int WIDTH = 17
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lvp_pkg::cell_cmd_type cmd,
   input  logic [WIDTH-1:0]     up_data,
   input  logic [WIDTH-1:0]     down_data,
   input  logic [WIDTH-1:0]     load_data,
   output logic [WIDTH-1:0]     value
);
   import lvp_pkg::*;

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;

   always_comb begin
      priority if (cmd.push) begin
         value_in = up_data;
      end else if (cmd.pop) begin
         value_in = down_data;
      end else if (cmd.load) begin
         value_in = load_data;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: src/lvp_ctrl.sv
module lvp_ctrl #(
   parameter int STACK_DEPTH   = lvp_pkg::DEF_STACK_DEPTH,
   parameter int POSITION_BITS = lvp_pkg::DEF_POSITION_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [lvp_pkg::SYMBOL_W-1:0]   symbol,
   input  logic                           first,
   input  logic [POSITION_BITS:0]         top_value,
   input  logic [POSITION_BITS:0]         next_value,
   output lvp_pkg::cell_cmd_type          cmd_head,
   output lvp_pkg::cell_cmd_type          cmd_rest,
   output logic [POSITION_BITS:0]         tag,
   output logic [POSITION_BITS:0]         base_view,
   output logic [POSITION_BITS:0]         load_value,
   output logic [lvp_pkg::LONGEST_W-1:0]  longest_in,
   output logic                           overflow_in
);
   import lvp_pkg::*;

   localparam int TW = POSITION_BITS + 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int EW = (TW > LONGEST_W) ? TW : LONGEST_W;

   logic [DW-1:0] top_ff,  top_in,  eff_top;
   logic [TW-1:0] pos_ff,  pos_in,  eff_pos;
   logic [TW-1:0] best_ff, best_in, eff_best;
   logic          ovf_ff,  ovf_in,  eff_ovf;
   logic [TW-1:0] run;
   logic [EW-1:0] best_ext;
   cell_cmd_type  head_raw, rest_raw;

   always_comb begin
      eff_top   = first ? '0 : top_ff;
      eff_pos   = first ? '0 : pos_ff;
      eff_best  = first ? '0 : best_ff;
      eff_ovf   = first ? 1'b0 : ovf_ff;
      base_view = first ? '0 : top_value;
      tag       = eff_pos + TW'(1);
      run       = tag - next_value;

      top_in     = eff_top;
      pos_in     = eff_pos;
      best_in    = eff_best;
      ovf_in     = eff_ovf;
      head_raw   = '0;
      rest_raw   = '0;
      load_value = '0;
      head_raw.load = first;

      if (eff_pos[POSITION_BITS]) begin
         ovf_in = 1'b1;
      end else begin
         pos_in = eff_pos + TW'(1);
         if (symbol == SYM_OPEN) begin
            if (eff_top == DW'(STACK_DEPTH)) begin
               ovf_in = 1'b1;
            end else begin
               top_in        = eff_top + DW'(1);
               head_raw.push = 1'b1;
               rest_raw.push = 1'b1;
            end
         end else if (symbol == SYM_CLOSE) begin
            if (eff_top != '0) begin
               top_in       = eff_top - DW'(1);
               head_raw.pop = 1'b1;
               rest_raw.pop = 1'b1;
               if (run > eff_best) begin
                  best_in = run;
               end
            end else begin
               head_raw.load = 1'b1;
               load_value    = tag;
            end
         end
      end

      cmd_head    = accept ? head_raw : '0;
      cmd_rest    = accept ? rest_raw : '0;
      best_ext    = EW'(best_in);
      longest_in  = best_ext[LONGEST_W-1:0];
      overflow_in = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff  <= '0;
         pos_ff  <= '0;
         best_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (accept) begin
         top_ff  <= top_in;
         pos_ff  <= pos_in;
         best_ff <= best_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

// File: src/longest_valid_parentheses_unit.sv
// A result beat is registered and appears in the cycle after its character is accepted.
// Throughput: one character per cycle while no result beat is held stalled;
// with a shift-cell position stack, push or pop and a subtract-compare both fit.
// Reset (synchronous, active high) empties the stack to its base entry, clears
// position, longest run and overflow, and drops any pending result beat.
module longest_valid_parentheses_unit #(
   parameter int STACK_DEPTH   = lvp_pkg::DEF_STACK_DEPTH,
   parameter int POSITION_BITS = lvp_pkg::DEF_POSITION_BITS
) (
   input  logic     clock,
   input  logic     reset,
   lvp_req_if.sink   req_chan,
   lvp_rsp_if.source rsp_chan
);
   import lvp_pkg::*;

   localparam int TW    = POSITION_BITS + 1;
   localparam int NCELL = STACK_DEPTH + 1;

   logic                 accept;
   cell_cmd_type         cmd_head, cmd_rest;
   logic [TW-1:0]        tag, base_view, load_value;
   logic [TW-1:0]        cell_value [NCELL];
   logic [LONGEST_W-1:0] longest_in, longest_ff;
   logic                 overflow_in, overflow_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   lvp_ctrl #(
      .STACK_DEPTH  (STACK_DEPTH),
      .POSITION_BITS(POSITION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .symbol     (req_chan.symbol),
      .first      (req_chan.first),
      .top_value  (cell_value[0]),
      .next_value (cell_value[1]),
      .cmd_head   (cmd_head),
      .cmd_rest   (cmd_rest),
      .tag        (tag),
      .base_view  (base_view),
      .load_value (load_value),
      .longest_in (longest_in),
      .overflow_in(overflow_in)
   );

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      logic [TW-1:0] up_data, down_data, load_data;
      cell_cmd_type  cmd;

      if (i == 0) begin : g_head
         assign up_data   = tag;
         assign load_data = load_value;
         assign cmd       = cmd_head;
      end else begin : g_body
         assign up_data   = (i == 1) ? base_view : cell_value[i-1];
         assign load_data = '0;
         assign cmd       = cmd_rest;
      end

      if (i == NCELL - 1) begin : g_tail
         assign down_data = '0;
      end else begin : g_link
         assign down_data = cell_value[i+1];
      end

      lvp_cell #(
         .WIDTH(TW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .up_data  (up_data),
         .down_data(down_data),
         .load_data(load_data),
         .value    (cell_value[i])
      );
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         longest_ff  <= longest_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.longest  = longest_ff;
   assign rsp_chan.overflow = overflow_ff;

endmodule

// File: src/lvp_chk.sv
module lvp_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [lvp_pkg::SYMBOL_W-1:0]  req_symbol,
   input logic                          req_first,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lvp_pkg::LONGEST_W-1:0] rsp_longest,
   input logic                          rsp_overflow
);
   import lvp_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat pending after reset");

   a_beat_to_result: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_valid)
      else $error("accepted beat produced no result");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_first && req_symbol != SYM_OPEN) |=>
         (rsp_longest == '0 && !rsp_overflow))
      else $error("first beat of a string left stale state");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_longest) && $stable(rsp_overflow)))
      else $error("stalled result beat changed");

endmodule

bind longest_valid_parentheses_unit lvp_chk u_lvp_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_symbol  (req_chan.symbol),
   .req_first   (req_chan.first),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_longest (rsp_chan.longest),
   .rsp_overflow(rsp_chan.overflow)
);

// File: tb/sv/tb_top.sv
module tb_top;
   import lvp_pkg::*;

   localparam int POS_LIMIT   = 1 << DEF_POSITION_BITS;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int RANDOM_BEATS = 1300;

   typedef struct packed {
      logic [LONGEST_W-1:0] longest;
      logic                 overflow;
   } run_result_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0]  symbol;
      logic                 first;
      logic                 known;
      logic [LONGEST_W-1:0] longest;
      logic                 overflow;
   } char_row_type;

   typedef enum int {
      SHAPE_BALANCED,
      SHAPE_MIXED,
      SHAPE_DEEP,
      SHAPE_NOISE
   } shape_type;

   localparam int DIRECTED_ROWS = 22;

   char_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{SYM_CLOSE, 1'b0, 1'b1, 17'd0, 1'b0},
      '{SYM_OPEN,  1'b0, 1'b1, 17'd0, 1'b0},
      '{SYM_CLOSE, 1'b0, 1'b1, 17'd2, 1'b0},
      '{8'h00,     1'b0, 1'b1, 17'd2, 1'b0},
      '{8'hFF,     1'b0, 1'b1, 17'd2, 1'b0},
      '{SYM_OPEN,  1'b0, 1'b0, 17'd0, 1'b0},
      '{SYM_OPEN,  1'b0, 1'b0, 17'd0, 1'b0},
      '{SYM_CLOSE, 1'b0, 1'b0, 17'd0, 1'b0},
      '{SYM_CLOSE, 1'b0, 1'b0, 17'd0, 1'b0},
      '{SYM_CLOSE, 1'b1, 1'b1, 17'd0, 1'b0},
      '{SYM_OPEN,  1'b1, 1'b1, 17'd0, 1'b0},
      '{SYM_CLOSE, 1'b0, 1'b1, 17'd2, 1'b0},
      '{8'h27,     1'b0, 1'b0, 17'd0, 1'b0},
      '{8'h2A,     1'b0, 1'b0, 17'd0, 1'b0},
      '{SYM_OPEN,  1'b1, 1'b1, 17'd0, 1'b0},
      '{SYM_CLOSE, 1'b1, 1'b1, 17'd0, 1'b0},
      '{SYM_CLOSE, 1'b0, 1'b0, 17'd0, 1'b0},
      '{SYM_OPEN,  1'b0, 1'b0, 17'd0, 1'b0},
      '{SYM_CLOSE, 1'b0, 1'b0, 17'd0, 1'b0},
      '{8'h80,     1'b1, 1'b1, 17'd0, 1'b0},
      '{8'h7F,     1'b0, 1'b0, 17'd0, 1'b0},
      '{8'h01,     1'b0, 1'b0, 17'd0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   lvp_req_if req_chan ();
   lvp_rsp_if rsp_chan ();

   longest_valid_parentheses_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #6 clock = ~clock;

   logic [LONGEST_W-1:0] pos_stack [0:DEF_STACK_DEPTH];
   int unsigned          stack_top_idx;
   logic [LONGEST_W-1:0] next_pos;
   logic [LONGEST_W-1:0] best_run;
   logic                 overflow_flag;

   run_result_type longest_expected [$];
   int          error_count   = 0;
   int          beats_sent    = 0;
   int          cycle_count   = 0;
   bit          idle_enabled  = 1'b1;
   bit          hold_request  = 1'b0;

   function automatic void clear_scan();
      foreach (pos_stack[i]) pos_stack[i] = '0;
      stack_top_idx = 0;
      next_pos      = '0;
      best_run      = '0;
      overflow_flag = 1'b0;
   endfunction

   function automatic run_result_type scan_char(input logic [SYMBOL_W-1:0] sym,
                                                input logic first);
      run_result_type       res;
      logic [LONGEST_W-1:0] tag;
      logic [LONGEST_W-1:0] run;
      if (first) clear_scan();
      if (int'(next_pos) >= POS_LIMIT) begin
         overflow_flag = 1'b1;
      end else begin
         tag = next_pos + 1'b1;
         if (sym == SYM_OPEN) begin
            if (stack_top_idx >= DEF_STACK_DEPTH) begin
               overflow_flag = 1'b1;
            end else begin
               stack_top_idx++;
               pos_stack[stack_top_idx] = tag;
            end
         end else if (sym == SYM_CLOSE) begin
            if (stack_top_idx >= 1) begin
               stack_top_idx--;
               run = tag - pos_stack[stack_top_idx];
               if (run > best_run) best_run = run;
            end else begin
               stack_top_idx = 0;
               pos_stack[0]  = tag;
            end
         end
         next_pos = next_pos + 1'b1;
      end
      res.longest  = best_run;
      res.overflow = overflow_flag;
      return res;
   endfunction

   task automatic send_beat(input logic [SYMBOL_W-1:0] sym, input logic first,
                            input logic known, input logic [LONGEST_W-1:0] longest,
                            input logic overflow);
      run_result_type want;
      int          gap;
      if (idle_enabled && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid  <= 1'b1;
      req_chan.symbol <= sym;
      req_chan.first  <= first;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      want = scan_char(sym, first);
      if (known) begin
         want.longest  = longest;
         want.overflow = overflow;
      end
      longest_expected.push_back(want);
      beats_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (longest_expected.size() != 0) @(posedge clock);
   endtask

   task automatic send_string(input shape_type shape);
      int                  len;
      int                  depth;
      int                  k;
      int                  r;
      logic [SYMBOL_W-1:0] sym;
      logic                first;
      first = ($urandom_range(0, 7) != 0);
      case (shape)
         SHAPE_BALANCED: begin
            if ($urandom_range(0, 3) == 0) begin
               send_beat(SYM_CLOSE, first, 1'b0, '0, 1'b0);
               first = 1'b0;
            end
            len   = 2 * $urandom_range(1, 24);
            depth = 0;
            for (int i = 0; i < len; i++) begin
               if (depth == 0 || (len - i > depth && $urandom_range(0, 1) == 1)) begin
                  sym = SYM_OPEN;
                  depth++;
               end else begin
                  sym = SYM_CLOSE;
                  depth--;
               end
               if ($urandom_range(0, 15) == 0) sym = SYMBOL_W'($urandom_range(0, 255));
               send_beat(sym, first, 1'b0, '0, 1'b0);
               first = 1'b0;
            end
         end
         SHAPE_MIXED: begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(0, 9);
               if (r < 4)      sym = SYM_OPEN;
               else if (r < 8) sym = SYM_CLOSE;
               else            sym = SYMBOL_W'($urandom_range(0, 255));
               send_beat(sym, first, 1'b0, '0, 1'b0);
               first = 1'b0;
            end
         end
         SHAPE_DEEP: begin
            k = $urandom_range(60, 70);
            for (int i = 0; i < k; i++) begin
               send_beat(SYM_OPEN, first, 1'b0, '0, 1'b0);
               first = 1'b0;
            end
            len = k + $urandom_range(0, 2);
            for (int i = 0; i < len; i++) begin
               sym = ($urandom_range(0, 31) == 0) ? SYMBOL_W'($urandom_range(0, 255))
                                                 : SYM_CLOSE;
               send_beat(sym, 1'b0, 1'b0, '0, 1'b0);
            end
         end
         default: begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               send_beat(SYMBOL_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                         1'b0, '0, 1'b0);
            end
         end
      endcase
   endtask

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      run_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (longest_expected.size() == 0) begin
            $display("%0t: unexpected beat, longest %0d overflow %0b", $time,
                     rsp_chan.longest, rsp_chan.overflow);
            error_count++;
         end else begin
            want = longest_expected.pop_front();
            if (rsp_chan.longest !== want.longest) begin
               $display("%0t: longest expected %0d, actual %0d", $time,
                        want.longest, rsp_chan.longest);
               error_count++;
            end
            if (rsp_chan.overflow !== want.overflow) begin
               $display("%0t: overflow expected %0b, actual %0b", $time,
                        want.overflow, rsp_chan.overflow);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      int        pick;
      bit        hold_done;
      shape_type shape;
      hold_done       = 1'b0;
      req_chan.valid  = 1'b0;
      req_chan.symbol = '0;
      req_chan.first  = 1'b0;
      clear_scan();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_beat(directed_rows[i].symbol, directed_rows[i].first, directed_rows[i].known,
                   directed_rows[i].longest, directed_rows[i].overflow);
      end
      wait_drained();

      while (beats_sent < RANDOM_BEATS) begin
         pick = $urandom_range(0, 15);
         if (pick < 8)        shape = SHAPE_BALANCED;
         else if (pick < 13)  shape = SHAPE_MIXED;
         else if (pick == 13) shape = SHAPE_DEEP;
         else                 shape = SHAPE_NOISE;
         send_string(shape);
         if (!hold_done && beats_sent > 700) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if ($urandom_range(0, 11) == 0) wait_drained();
      end

      // closing strings back to back with no idling
      idle_enabled = 1'b0;
      send_string(SHAPE_DEEP);
      send_string(SHAPE_BALANCED);
      send_string(SHAPE_MIXED);

      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0 && longest_expected.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
